// ===== rtl/rqtp_pkg.sv =====
// shared types and constants for the ring queue with tail pop
// no dependencies; imported by the controller, datapath and top level
package rqtp_pkg;

  // operation selector carried by each input beat
  typedef enum logic [1:0] {
    FUNC_ENQ      = 2'd0,
    FUNC_POP_HEAD = 2'd1,
    FUNC_POP_TAIL = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;   // perform the operation of the beat taken this cycle
    logic rd_en;  // latch head and tail entries from the store
  } cmd_t;

  localparam int          CAP_BITS   = 5;
  localparam int          SLOT_BITS  = 4;
  localparam logic [4:0]  CAP_RESET  = 5'd16;
  localparam int          CAP_LIMIT  = 31;

endpackage

// ===== rtl/rqtp_ctrl.sv =====
// sequencer for the ring queue: take a beat, read back head and tail, present result
// depends on rqtp_pkg
module rqtp_ctrl
  import rqtp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_RESP);
    cmd.exec  = (state == ST_IDLE) && in_valid;
    cmd.rd_en = (state == ST_READ);
  end

`ifndef NO_ASSERTIONS
  a_exec_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> cmd.rd_en)
    else $error("operation not followed by read-back");
  a_read_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> out_valid)
    else $error("read-back not followed by result");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (out_valid || cmd.rd_en) |-> in_stall)
    else $error("input open while an item is in flight");
`endif

endmodule

// ===== rtl/rqtp_dpath.sv =====
// datapath of the ring queue: pointers, count, entry store and result registers
// depends on rqtp_pkg; driven by rqtp_ctrl commands
module rqtp_dpath
  import rqtp_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic                  cfg_wr_en,
  input  logic [CAP_BITS-1:0]   cfg_wr_data,
  input  logic [1:0]            func,
  input  logic signed [31:0]    key,
  input  logic [31:0]           payload,
  output logic                  accepted,
  output logic [SLOT_BITS-1:0]  written_slot,
  output logic [CAP_BITS-1:0]   count,
  output logic signed [31:0]    head_key,
  output logic [31:0]           head_payload,
  output logic signed [31:0]    tail_key,
  output logic [31:0]           tail_payload
);

  localparam int IW      = $clog2(DEPTH);
  localparam int PW      = (IW < CAP_BITS) ? IW : CAP_BITS;
  localparam int SW      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int EW      = 32 + SW;
  localparam int CAP_MAX = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam logic [CAP_BITS-1:0] CAP_RST =
    (CAP_MAX < int'(CAP_RESET)) ? CAP_BITS'(CAP_MAX) : CAP_RESET;

  logic [EW-1:0] store [DEPTH];

  logic [PW-1:0]       head;
  logic [PW-1:0]       tail;
  logic [CAP_BITS-1:0] cnt;
  logic [CAP_BITS-1:0] cap;

  logic [PW-1:0]       head_next;
  logic [PW-1:0]       tail_next;
  logic [CAP_BITS-1:0] cnt_next;
  logic                acc_next;
  logic [CAP_BITS-1:0] cap_in;
  logic                wr_en;
  logic [EW-1:0]       wr_data;

  logic [CAP_BITS-1:0] head_inc;
  logic [CAP_BITS-1:0] tail_inc;
  logic [CAP_BITS-1:0] tail_fwd;
  logic [CAP_BITS-1:0] tail_back;

  logic [EW-1:0] head_q;
  logic [EW-1:0] tail_q;
  logic          acc_q;
  logic [SLOT_BITS-1:0] slot_q;

  // clamp written capacity into 1..min(DEPTH, 31)
  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_in = CAP_BITS'(1);
    end else if (cfg_wr_data > CAP_BITS'(CAP_MAX)) begin
      cap_in = CAP_BITS'(CAP_MAX);
    end else begin
      cap_in = cfg_wr_data;
    end
  end

  always_comb begin
    head_inc  = CAP_BITS'(head) + CAP_BITS'(1);
    tail_inc  = CAP_BITS'(tail) + CAP_BITS'(1);
    tail_fwd  = (tail_inc >= cap) ? '0 : tail_inc;
    tail_back = (tail == '0) ? (cap - CAP_BITS'(1)) : (CAP_BITS'(tail) - CAP_BITS'(1));
    wr_data   = {key, payload[SW-1:0]};

    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    acc_next  = 1'b0;
    wr_en     = 1'b0;
    unique case (func_t'(func))
      FUNC_ENQ: begin
        if (cnt < cap) begin
          tail_next = PW'(tail_fwd);
          cnt_next  = cnt + CAP_BITS'(1);
          acc_next  = 1'b1;
          wr_en     = 1'b1;
        end
      end
      FUNC_POP_HEAD: begin
        if (cnt != '0) begin
          head_next = (head_inc >= cap) ? '0 : PW'(head_inc);
          cnt_next  = cnt - CAP_BITS'(1);
          acc_next  = 1'b1;
        end
      end
      FUNC_POP_TAIL: begin
        if (cnt != '0) begin
          tail_next = PW'(tail_back);
          cnt_next  = cnt - CAP_BITS'(1);
          acc_next  = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        head_next = '0;
        tail_next = PW'(cap - CAP_BITS'(1));
        cnt_next  = '0;
        acc_next  = 1'b1;
      end
      default: begin
        acc_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CAP_RST;
      head <= '0;
      tail <= PW'(CAP_RST - CAP_BITS'(1));
      cnt  <= '0;
    end else if (cfg_wr_en) begin
      // a capacity write empties the queue
      cap  <= cap_in;
      head <= '0;
      tail <= PW'(cap_in - CAP_BITS'(1));
      cnt  <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_q  <= acc_next;
      slot_q <= wr_en ? SLOT_BITS'(tail_fwd) : '0;
    end
  end

  // entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en && !cfg_wr_en) begin
      store[IW'(tail_fwd)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      head_q <= store[IW'(head)];
      tail_q <= store[IW'(tail)];
    end
  end

  always_comb begin
    accepted     = acc_q;
    written_slot = slot_q;
    count        = cnt;
    if (cnt == '0) begin
      head_key     = '0;
      head_payload = '0;
      tail_key     = '0;
      tail_payload = '0;
    end else begin
      head_key     = head_q[EW-1 -: 32];
      head_payload = 32'(head_q[SW-1:0]);
      tail_key     = tail_q[EW-1 -: 32];
      tail_payload = 32'(tail_q[SW-1:0]);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= cap)
    else $error("count above capacity");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CAP_BITS'(head) < cap) && (CAP_BITS'(tail) < cap))
    else $error("pointer outside capacity");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (cnt == '0) && (head == '0))
    else $error("capacity write did not empty the queue");
`endif

endmodule

// ===== rtl/ring_queue_with_tail_pop_unit.sv =====
// ring queue with enqueue, head pop, tail pop and clear; one operation per beat
// a beat is taken in the idle state, head and tail are read back in the read state, and the
// result is held in the response state while out_stall is high; no new beat until it is taken
// reset: head and count cleared, tail at capacity minus one, capacity 16 (clamped to DEPTH);
// store not cleared
// depends on rqtp_pkg, rqtp_ctrl, rqtp_dpath
module ring_queue_with_tail_pop_unit
  import rqtp_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CAP_BITS-1:0]   cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic signed [31:0]    key,
  input  logic [31:0]           payload,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  accepted,
  output logic [SLOT_BITS-1:0]  written_slot,
  output logic [CAP_BITS-1:0]   count,
  output logic signed [31:0]    head_key,
  output logic [31:0]           head_payload,
  output logic signed [31:0]    tail_key,
  output logic [31:0]           tail_payload
);

  cmd_t cmd;

  rqtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rqtp_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .func         (func),
    .key          (key),
    .payload      (payload),
    .accepted     (accepted),
    .written_slot (written_slot),
    .count        (count),
    .head_key     (head_key),
    .head_payload (head_payload),
    .tail_key     (tail_key),
    .tail_payload (tail_payload)
  );

endmodule

// ===== tb/sv/tb_ring_queue_with_tail_pop_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for ring_queue_with_tail_pop_unit: a queue-fed driver, a monitor
// and an in-bench model of the ring queue; depends on rqtp_pkg and the unit's rtl
module tb_ring_queue_with_tail_pop_unit;
  import rqtp_pkg::*;

  localparam int DEPTH = 16;

  typedef struct packed {
    func_t       op;
    logic [31:0] k;
    logic [31:0] p;
  } queue_op_t;

  typedef struct packed {
    logic        acc;
    logic [3:0]  slot;
    logic [4:0]  cnt;
    logic [31:0] hk;
    logic [31:0] hp;
    logic [31:0] tk;
    logic [31:0] tp;
  } queue_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [31:0] key = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic [3:0]  written_slot;
  logic [4:0]  count;
  logic [31:0] head_key;
  logic [31:0] head_payload;
  logic [31:0] tail_key;
  logic [31:0] tail_payload;

  ring_queue_with_tail_pop_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .key          (key),
    .payload      (payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .written_slot (written_slot),
    .count        (count),
    .head_key     (head_key),
    .head_payload (head_payload),
    .tail_key     (tail_key),
    .tail_payload (tail_payload)
  );

  always #5 clk = ~clk;

  // model of the queue
  logic [31:0] mdl_keys [DEPTH];
  logic [31:0] mdl_pays [DEPTH];
  int          mdl_head;
  int          mdl_tail;
  int          mdl_count;
  logic [4:0]  mdl_cap_reg;

  queue_op_t   op_queue[$];
  queue_view_t pending_views[$];
  queue_op_t   cur_op;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int n_beats = 0;
  int n_results = 0;
  int n_rejects = 0;
  int n_tail_wraps = 0;
  int n_caps = 0;

  function automatic int eff_capacity();
    if (mdl_cap_reg == 5'd0) return 1;
    if (mdl_cap_reg > DEPTH) return DEPTH;
    return int'(mdl_cap_reg);
  endfunction

  function automatic void clear_pointers();
    mdl_head  = 0;
    mdl_tail  = eff_capacity() - 1;
    mdl_count = 0;
  endfunction

  function automatic queue_view_t apply_queue_op(queue_op_t qo);
    queue_view_t v;
    int cap;
    v = '0;
    cap = eff_capacity();
    if (mdl_head >= cap || mdl_tail >= cap || mdl_count > cap) clear_pointers();
    case (qo.op)
      FUNC_ENQ: begin
        if (mdl_count < cap) begin
          mdl_tail = (mdl_tail + 1 >= cap) ? 0 : mdl_tail + 1;
          mdl_keys[mdl_tail[3:0]] = qo.k;
          mdl_pays[mdl_tail[3:0]] = qo.p;
          mdl_count++;
          v.slot = mdl_tail[3:0];
          v.acc = 1'b1;
        end
      end
      FUNC_POP_HEAD: begin
        if (mdl_count > 0) begin
          mdl_count--;
          mdl_head = (mdl_head + 1 >= cap) ? 0 : mdl_head + 1;
          v.acc = 1'b1;
        end
      end
      FUNC_POP_TAIL: begin
        if (mdl_count > 0) begin
          mdl_count--;
          if (mdl_tail == 0) n_tail_wraps++;
          mdl_tail = (mdl_tail == 0) ? cap - 1 : mdl_tail - 1;
          v.acc = 1'b1;
        end
      end
      default: begin
        clear_pointers();
        v.acc = 1'b1;
      end
    endcase
    if (!v.acc) n_rejects++;
    v.cnt = mdl_count[4:0];
    if (mdl_count > 0) begin
      v.hk = mdl_keys[mdl_head[3:0]];
      v.hp = mdl_pays[mdl_head[3:0]];
      v.tk = mdl_keys[mdl_tail[3:0]];
      v.tp = mdl_pays[mdl_tail[3:0]];
    end
    return v;
  endfunction

  // driver: next beat goes out once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_views.push_back(apply_queue_op(cur_op));
        n_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = op_queue.pop_front();
          in_valid <= 1'b1;
          func     <= cur_op.op;
          key      <= cur_op.k;
          payload  <= cur_op.p;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    queue_view_t got;
    queue_view_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {accepted, written_slot, count, head_key, head_payload, tail_key, tail_payload};
        n_results++;
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: acc=%0d slot=%0d count=%0d", got.acc, got.slot,
                     got.cnt);
        end else begin
          want = pending_views.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result %0d:", n_results);
              $display("  acc  exp %0d got %0d, slot exp %0d got %0d, count exp %0d got %0d",
                       want.acc, got.acc, want.slot, got.slot, want.cnt, got.cnt);
              $display("  head exp %h/%h got %h/%h", want.hk, want.hp, got.hk, got.hp);
              $display("  tail exp %h/%h got %h/%h", want.tk, want.tp, got.tk, got.tp);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(func_t op, logic [31:0] k, logic [31:0] p);
    queue_op_t qo;
    qo.op = op;
    qo.k  = k;
    qo.p  = p;
    op_queue.push_back(qo);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (op_queue.size() != 0 || pending_views.size() != 0 || in_valid);
  endtask

  task automatic write_capacity(logic [4:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mdl_cap_reg = value;
    clear_pointers();
    n_caps++;
  endtask

  // runs of fill-biased and drain-biased ops so the queue reaches full and empty often
  task automatic queue_random_ops(int n, int cap);
    int run_left;
    bit filling;
    int r;
    func_t op;
    run_left = 0;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        filling = ~filling;
        run_left = $urandom_range(2 * cap + 2, 1);
      end
      run_left--;
      r = $urandom_range(99);
      if (r < 8) op = func_t'($urandom_range(3));
      else if (r < 11) op = FUNC_CLEAR;
      else if (filling) op = (r < 80) ? FUNC_ENQ : (r < 90) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
      else op = (r < 30) ? FUNC_ENQ : (r < 65) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
      push_op(op, pick_word(), pick_word());
    end
  endtask

  initial begin
    logic [4:0] caps [10];
    int eff;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd2, 5'd5, 5'd8, 5'd16};
    for (int i = 0; i < DEPTH; i++) begin
      mdl_keys[i] = '0;
      mdl_pays[i] = '0;
    end
    mdl_cap_reg = CAP_RESET;
    clear_pointers();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // out of reset: removals on empty, field extremes, both pops, clear
    push_op(FUNC_POP_HEAD, 32'h1234_5678, 32'h9abc_def0);
    push_op(FUNC_POP_TAIL, 32'hffff_ffff, 32'hffff_ffff);
    push_op(FUNC_ENQ, 32'h8000_0000, 32'h0000_0000);
    push_op(FUNC_ENQ, 32'h7fff_ffff, 32'hffff_ffff);
    push_op(FUNC_ENQ, 32'hffff_ffff, 32'h5555_5555);
    push_op(FUNC_ENQ, 32'h0000_0000, 32'haaaa_aaaa);
    push_op(FUNC_POP_TAIL, '0, '0);
    push_op(FUNC_POP_HEAD, '0, '0);
    push_op(FUNC_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    push_op(FUNC_ENQ, 32'h0000_0001, 32'h8000_0000);
    wait_idle();

    // capacity two: full reject, tail wrap forward, tail step back from slot 0
    write_capacity(5'd2);
    push_op(FUNC_ENQ, 32'h0000_00a0, 32'h0000_00b0);
    push_op(FUNC_ENQ, 32'h0000_00a1, 32'h0000_00b1);
    push_op(FUNC_ENQ, 32'h0000_00a2, 32'h0000_00b2);
    push_op(FUNC_POP_HEAD, '0, '0);
    push_op(FUNC_ENQ, 32'h0000_00a3, 32'h0000_00b3);
    push_op(FUNC_POP_TAIL, '0, '0);
    push_op(FUNC_POP_TAIL, '0, '0);
    push_op(FUNC_POP_TAIL, '0, '0);
    push_op(FUNC_POP_HEAD, '0, '0);
    push_op(FUNC_ENQ, 32'h0000_00a4, 32'h0000_00b4);
    push_op(FUNC_CLEAR, '0, '0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      write_capacity(caps[ph]);
      eff = eff_capacity();
      queue_random_ops(46, eff);
      // sender holds off here until every result is back
      wait_idle();
      queue_random_ops(46, eff);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("ran %0d beats over %0d capacity settings: %0d rejected, %0d tail wraps",
             n_beats, n_caps, n_rejects, n_tail_wraps);
    $display("%0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_views.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rqtp_pkg.sv
rtl/rqtp_ctrl.sv
rtl/rqtp_dpath.sv
rtl/ring_queue_with_tail_pop_unit.sv
tb/sv/tb_ring_queue_with_tail_pop_unit.sv
